// ===== sv/nl2sc_pkg.sv =====
package nl2sc_pkg;

  localparam int unsigned LengthBits = 24;
  localparam int unsigned CountW     = 24;
  localparam int unsigned AccumW     = 32;
  localparam int unsigned CfgW       = 3;

  localparam logic [AccumW-1:0] MaxLen = AccumW'((64'd1 << LengthBits) - 64'd1);
  localparam logic [CfgW-1:0]   PrefixSizeRst = CfgW'(4);

  typedef struct packed {
    logic [7:0]        data_byte;
    logic              first_of_buffer;
    logic [CountW-1:0] buffer_length;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       malformed;
    logic       buffer_done;
  } result_t;

endpackage

// ===== sv/nl2sc_in_stage.sv =====
module nl2sc_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  nl2sc_pkg::item_t   item_i,
  output logic               valid_o,
  input  logic               take_i,
  output nl2sc_pkg::item_t   item_o
);

  logic             valid_q;
  nl2sc_pkg::item_t item_q;
  logic             load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== sv/nl2sc_out_stage.sv =====
module nl2sc_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  nl2sc_pkg::result_t  res_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output nl2sc_pkg::result_t  res_o
);

  logic               valid_q;
  nl2sc_pkg::result_t res_q;
  logic               load;

  assign ready_o = !valid_q || res_ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (res_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== sv/nl2sc_conv.sv =====
module nl2sc_conv (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [nl2sc_pkg::CfgW-1:0]        cfg_wdata_i,
  input  logic                              valid_i,
  input  nl2sc_pkg::item_t                  item_i,
  input  logic                              ready_i,
  output logic                              take_o,
  output nl2sc_pkg::result_t                res_o
);

  logic [nl2sc_pkg::CfgW-1:0]   prefix_size_q;
  logic                         in_payload_q, in_payload_d;
  logic [1:0]                   prefix_index_q, prefix_index_d;
  logic [nl2sc_pkg::AccumW-1:0] length_accum_q, length_accum_d;
  logic [nl2sc_pkg::CountW-1:0] payload_left_q, payload_left_d;
  logic [nl2sc_pkg::CountW-1:0] bytes_left_q, bytes_left_d;
  logic                         error_seen_q, error_seen_d;
  logic                         tail_drop_q, tail_drop_d;

  assign take_o = valid_i && ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_size_q <= nl2sc_pkg::PrefixSizeRst;
    end else if (cfg_we_i) begin
      prefix_size_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q   <= 1'b0;
      prefix_index_q <= '0;
      length_accum_q <= '0;
      payload_left_q <= '0;
      bytes_left_q   <= '0;
      error_seen_q   <= 1'b0;
      tail_drop_q    <= 1'b0;
    end else if (take_o) begin
      in_payload_q   <= in_payload_d;
      prefix_index_q <= prefix_index_d;
      length_accum_q <= length_accum_d;
      payload_left_q <= payload_left_d;
      bytes_left_q   <= bytes_left_d;
      error_seen_q   <= error_seen_d;
      tail_drop_q    <= tail_drop_d;
    end
  end

  always_comb begin
    logic                         first;
    logic                         cur_in_payload;
    logic [1:0]                   cur_index;
    logic [nl2sc_pkg::AccumW-1:0] cur_accum;
    logic [nl2sc_pkg::CountW-1:0] cur_payload;
    logic                         cur_error;
    logic                         cur_tail;
    logic [nl2sc_pkg::CountW-1:0] rem;
    logic [nl2sc_pkg::CountW-1:0] after;
    logic [2:0]                   psize;
    logic [nl2sc_pkg::AccumW-1:0] acc_base;
    logic [nl2sc_pkg::AccumW-1:0] acc_new;
    logic [nl2sc_pkg::CountW-1:0] pl_dec;

    first          = item_i.first_of_buffer;
    cur_in_payload = first ? 1'b0 : in_payload_q;
    cur_index      = first ? 2'd0 : prefix_index_q;
    cur_accum      = first ? '0 : length_accum_q;
    cur_payload    = first ? '0 : payload_left_q;
    cur_error      = first ? 1'b0 : error_seen_q;
    cur_tail       = first ? 1'b0 : tail_drop_q;
    rem            = first ? item_i.buffer_length : bytes_left_q;
    after          = rem - nl2sc_pkg::CountW'(1);
    psize          = prefix_size_q[2] ? 3'd4 : 3'd3;
    acc_base       = (cur_index == 2'd0) ? '0 : cur_accum;
    acc_new        = {acc_base[nl2sc_pkg::AccumW-9:0], item_i.data_byte};
    pl_dec         = (cur_payload != '0) ? (cur_payload - nl2sc_pkg::CountW'(1))
                                         : cur_payload;

    in_payload_d   = cur_in_payload;
    prefix_index_d = cur_index;
    length_accum_d = cur_accum;
    payload_left_d = cur_payload;
    bytes_left_d   = first ? '0 : bytes_left_q;
    error_seen_d   = cur_error;
    tail_drop_d    = cur_tail;
    res_o          = '0;

    if (rem == '0) begin
      res_o.buffer_done = first;
    end else begin
      res_o.buffer_done = (rem == nl2sc_pkg::CountW'(1));
      bytes_left_d      = after;
      if (!(cur_error || cur_tail)) begin
        if (cur_in_payload) begin
          res_o.out_byte  = item_i.data_byte;
          res_o.out_valid = 1'b1;
          payload_left_d  = pl_dec;
          if (pl_dec == '0) begin
            in_payload_d   = 1'b0;
            prefix_index_d = 2'd0;
          end
        end else if (cur_index == 2'd0 && rem < nl2sc_pkg::CountW'(psize)) begin
          tail_drop_d = 1'b1;
        end else begin
          length_accum_d  = acc_new;
          res_o.out_valid = 1'b1;
          if ({1'b0, cur_index} + 3'd1 >= psize) begin
            res_o.out_byte = 8'h01;
            prefix_index_d = 2'd0;
            if (acc_new > nl2sc_pkg::AccumW'(after) || acc_new > nl2sc_pkg::MaxLen) begin
              error_seen_d = 1'b1;
            end else if (acc_new != '0) begin
              in_payload_d   = 1'b1;
              payload_left_d = acc_new[nl2sc_pkg::CountW-1:0];
            end
          end else begin
            prefix_index_d = cur_index + 2'd1;
          end
        end
      end
      res_o.malformed = error_seen_d;
    end
  end

  // payload copy never coexists with an error or a dropped tail
  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q |-> (!error_seen_q && !tail_drop_q))
    else $error("payload state alongside error or tail drop");

  a_index_in_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prefix_index_q != 2'd0) |-> !in_payload_q)
    else $error("prefix index set during payload");

  a_error_mutes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && error_seen_q && !item_i.first_of_buffer) |-> !res_o.out_valid)
    else $error("valid byte after malformed length");

  a_bytes_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && !item_i.first_of_buffer && bytes_left_q != '0)
    |=> bytes_left_q == $past(bytes_left_q) - nl2sc_pkg::CountW'(1))
    else $error("byte count did not step down");

endmodule

// ===== sv/nal_length_to_start_code.sv =====
// channel   | handshake                    | payload
// ----------+------------------------------+-------------------------------------------
// input     | in_valid_i / in_ready_o      | data_byte_i, first_of_buffer_i, buffer_length_i
// result    | res_valid_o / res_ready_i    | out_byte_o, out_valid_o, malformed_o, buffer_done_o
// config    | cfg_we_i (no wait)           | cfg_wdata_i (prefix_size)
//
// One byte per clock sustained while res_ready_i does not stall the result; a result passes
// through the input register and then the result register before it is offered.
// Input register, one pass of conversion logic, result register; buffer state updates
// as an item moves into the result register.
// Reset clears all buffer state and sets prefix_size to 4.
// A stalled result holds the result register; the input register still takes a byte if empty.
module nal_length_to_start_code (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [nl2sc_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          first_of_buffer_i,
  input  logic [nl2sc_pkg::CountW-1:0]  buffer_length_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [7:0]                    out_byte_o,
  output logic                          out_valid_o,
  output logic                          malformed_o,
  output logic                          buffer_done_o
);

  nl2sc_pkg::item_t   item_in, item_q;
  nl2sc_pkg::result_t res_d, res_q;
  logic               stage_valid;
  logic               take;
  logic               out_ready;

  assign item_in.data_byte       = data_byte_i;
  assign item_in.first_of_buffer = first_of_buffer_i;
  assign item_in.buffer_length   = buffer_length_i;

  nl2sc_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (item_in),
    .valid_o    (stage_valid),
    .take_i     (take),
    .item_o     (item_q)
  );

  nl2sc_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .valid_i     (stage_valid),
    .item_i      (item_q),
    .ready_i     (out_ready),
    .take_o      (take),
    .res_o       (res_d)
  );

  nl2sc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (stage_valid),
    .ready_o     (out_ready),
    .res_i       (res_d),
    .res_valid_o (res_valid_o),
    .res_ready_i (res_ready_i),
    .res_o       (res_q)
  );

  assign out_byte_o    = res_q.out_byte;
  assign out_valid_o   = res_q.out_valid;
  assign malformed_o   = res_q.malformed;
  assign buffer_done_o = res_q.buffer_done;

endmodule
